// ===== sv/fvnh_pkg.sv =====
// Package: payload types and register indexes of the fractal value-noise height block.
package fvnh_pkg;

  typedef struct packed {
    logic [11:0] pixel_y;
    logic [11:0] pixel_x;
  } in_item_t;

  typedef struct packed {
    logic [23:0] pixel_index;
    logic [15:0] height_q16;
  } out_item_t;

  typedef enum logic [1:0] {
    REG_NOISE_SEED    = 2'd0,
    REG_ROUGHNESS_Q15 = 2'd1,
    REG_OCTAVE_COUNT  = 2'd2,
    REG_RES_LOG2      = 2'd3
  } cfg_reg_t;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;

endpackage

// ===== sv/fvnh_octave.sv =====
// One octave of value noise: lattice, hash, smoothstep, bilinear blend, weighted sum.
module fvnh_octave #(
  parameter int K     = 0,
  parameter int CW    = 12,
  parameter int AW    = 25,
  parameter int ACC_W = 42
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [31:0]             seed,
  input  logic [15:0]             rough,
  input  logic [4:0]              rl,
  input  logic [4:0]              oc,
  input  logic                    in_v,
  input  logic [CW-1:0]           in_x,
  input  logic [CW-1:0]           in_y,
  input  logic signed [ACC_W-1:0] in_acc,
  input  logic [AW-1:0]           in_amp,
  output logic                    out_v,
  output logic [CW-1:0]           out_x,
  output logic [CW-1:0]           out_y,
  output logic signed [ACC_W-1:0] out_acc,
  output logic [AW-1:0]           out_amp
);

  localparam int NS = 8;
  localparam int PW = CW + K + 8;
  localparam logic [31:0] C1 = 32'd374761393;
  localparam logic [31:0] C2 = 32'd668265263;
  localparam logic [31:0] C4 = 32'd1274126177;
  localparam logic [31:0] KC = 32'(64'(K) * 64'd1013904223);

  typedef struct packed {
    logic [CW-1:0]           x;
    logic [CW-1:0]           y;
    logic signed [ACC_W-1:0] acc;
    logic [AW-1:0]           amp;
    logic [AW-1:0]           amp_n;
  } pass_t;

  function automatic logic signed [16:0] blend(input logic signed [16:0] a,
                                               input logic signed [16:0] b,
                                               input logic [15:0] w);
    logic signed [17:0] d;
    logic signed [34:0] p;
    logic signed [34:0] q;
    d = 18'(b) - 18'(a);
    p = 35'(d) * $signed({19'b0, w});
    if (p >= 0) q = (p + 35'sd16384) >>> 15;
    else        q = -(((-p) + 35'sd16384) >>> 15);
    return 17'(18'(a) + 18'(q));
  endfunction

  function automatic logic [15:0] mix16(input logic [31:0] h);
    return h[15:0] ^ h[28:13];
  endfunction

  function automatic logic signed [16:0] corner(input logic [15:0] m);
    logic [15:0] p;
    p = 16'(32'(m) * 32'(C4[15:0]));
    return $signed({~p[15], ~p[15], p[14:0]});
  endfunction

  logic  vld_r [NS];
  pass_t pass_r [NS];

  // stage 1
  logic [PW-1:0]    px_w, py_w;
  logic [PW+15:0]   pxl_w, pyl_w;
  logic [AW+15:0]   amp_p_w;
  pass_t            pass0_w;
  logic [7:0]       cx_r, cy_r;
  logic [15:0]      tx_r, ty_r;
  // stage 2
  logic [31:0]      sqx_r, sqy_r, hx_r, hy_r;
  logic [15:0]      tx2_r, ty2_r;
  // stage 3
  logic [49:0]      prx_r, pry_r;
  logic [15:0]      m00_r, m10_r, m01_r, m11_r;
  // stage 4
  logic [15:0]      wx_r, wy_r, wy5_r;
  logic signed [16:0] c00_r, c10_r, c01_r, c11_r;
  // stage 5..7
  logic signed [16:0] r0_r, r1_r, n_r;
  logic signed [ACC_W-1:0] prod_r;
  logic             en_w;
  // stage 8
  pass_t            pass_last_w;

  always_comb begin
    px_w    = PW'(in_x) << K;
    py_w    = PW'(in_y) << K;
    pxl_w   = (PW + 16)'(px_w) << (5'd16 - rl);
    pyl_w   = (PW + 16)'(py_w) << (5'd16 - rl);
    amp_p_w = (AW + 16)'(in_amp) * (AW + 16)'(rough) + (AW + 16)'(16384);
    pass0_w.x     = in_x;
    pass0_w.y     = in_y;
    pass0_w.acc   = in_acc;
    pass0_w.amp   = in_amp;
    pass0_w.amp_n = AW'(amp_p_w >> 15);
    en_w    = 5'(K) < oc;
    // stage 8: add the weighted octave only when this octave is in use
    pass_last_w     = pass_r[NS-2];
    pass_last_w.acc = en_w ? pass_r[NS-2].acc + prod_r : pass_r[NS-2].acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= in_v;
      for (int i = 1; i < NS; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    pass_r[0] <= pass0_w;
    for (int i = 1; i < NS - 1; i++) pass_r[i] <= pass_r[i-1];
    pass_r[NS-1] <= pass_last_w;
    // stage 1: lattice cell and fraction
    cx_r  <= 8'(px_w >> rl);
    cy_r  <= 8'(py_w >> rl);
    tx_r  <= pxl_w[15:0];
    ty_r  <= pyl_w[15:0];
    // stage 2: squares and hash products
    sqx_r <= 32'(tx_r) * 32'(tx_r);
    sqy_r <= 32'(ty_r) * 32'(ty_r);
    hx_r  <= 32'(cx_r) * C1;
    hy_r  <= 32'(cy_r) * C2;
    tx2_r <= tx_r;
    ty2_r <= ty_r;
    // stage 3: smoothstep product, corner hash sums
    prx_r <= 50'(sqx_r) * 50'(18'd196608 - 18'({tx2_r, 1'b0}));
    pry_r <= 50'(sqy_r) * 50'(18'd196608 - 18'({ty2_r, 1'b0}));
    m00_r <= mix16((hx_r + hy_r + seed) ^ KC);
    m10_r <= mix16((hx_r + C1 + hy_r + seed) ^ KC);
    m01_r <= mix16((hx_r + hy_r + C2 + seed) ^ KC);
    m11_r <= mix16((hx_r + C1 + hy_r + C2 + seed) ^ KC);
    // stage 4: weights rounded half up, corner values
    wx_r  <= 16'((prx_r + (50'd1 << 32)) >> 33);
    wy_r  <= 16'((pry_r + (50'd1 << 32)) >> 33);
    c00_r <= corner(m00_r);
    c10_r <= corner(m10_r);
    c01_r <= corner(m01_r);
    c11_r <= corner(m11_r);
    // stage 5: blend along x
    r0_r  <= blend(c00_r, c10_r, wx_r);
    r1_r  <= blend(c01_r, c11_r, wx_r);
    wy5_r <= wy_r;
    // stage 6: blend along y
    n_r   <= blend(r0_r, r1_r, wy5_r);
    // stage 7: weight by amplitude
    prod_r <= $signed(ACC_W'(n_r)) * $signed(ACC_W'(pass_r[5].amp));
  end

  assign out_v   = vld_r[NS-1];
  assign out_x   = pass_r[NS-1].x;
  assign out_y   = pass_r[NS-1].y;
  assign out_acc = pass_r[NS-1].acc;
  assign out_amp = en_w ? pass_r[NS-1].amp_n : pass_r[NS-1].amp;

endmodule

// ===== sv/fractal_value_noise_height.sv =====
// Top level: fractal value-noise height pipeline with configuration registers.
//
//  channel   ports                              moves
//  input     start, busy, in_item               pixel_x, pixel_y
//  result    out_strobe, out_item               height_q16, pixel_index
//  config    cfg_we, cfg_index, cfg_data        one register write
//
//  One item enters every cycle; busy is never raised.
//  The path is an input stage, eight stages per octave unit
//  (all MAX_OCTAVES units are always passed, unused ones hand the sum on) and an output stage.
//  Reset clears the valid bits and loads the register defaults.
//  Results appear for one cycle on out_strobe; the receiver cannot stall.
module fractal_value_noise_height #(
  parameter int MAX_OCTAVES  = 8,
  parameter int MAX_RES_LOG2 = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  fvnh_pkg::in_item_t                  in_item,
  output logic                                out_strobe,
  output fvnh_pkg::out_item_t                 out_item,
  input  logic                                cfg_we,
  input  logic [fvnh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fvnh_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CW    = MAX_RES_LOG2;
  localparam int AW    = 17 + MAX_OCTAVES;
  localparam int ACC_W = 34 + MAX_OCTAVES;
  localparam int MO    = MAX_OCTAVES;

  // configuration registers
  logic [31:0] seed_r;
  logic [15:0] rough_r;
  logic [3:0]  oct_r;
  logic [3:0]  res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r  <= 32'd0;
      rough_r <= 16'd16384;
      oct_r   <= 4'd4;
      res_r   <= 4'd8;
    end else if (cfg_we) begin
      unique case (fvnh_pkg::cfg_reg_t'(cfg_index))
        fvnh_pkg::REG_NOISE_SEED:    seed_r  <= cfg_data;
        fvnh_pkg::REG_ROUGHNESS_Q15: rough_r <= cfg_data[15:0];
        fvnh_pkg::REG_OCTAVE_COUNT:  oct_r   <= cfg_data[3:0];
        fvnh_pkg::REG_RES_LOG2:      res_r   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // clamped octave count and resolution; the user must keep them stable while items are in flight, not enforced here
  logic [4:0]  rl_w, oc_w;
  logic [16:0] mask_w;
  always_comb begin
    rl_w = {1'b0, res_r};
    if (rl_w < 5'd1) rl_w = 5'd1;
    if (rl_w > 5'(MAX_RES_LOG2)) rl_w = 5'(MAX_RES_LOG2);
    oc_w = {1'b0, oct_r};
    if (oc_w > 5'(MAX_OCTAVES)) oc_w = 5'(MAX_OCTAVES);
    mask_w = (17'd1 << rl_w) - 17'd1;
  end

  assign busy = 1'b0;

  // octave chain, entry 0 is the input stage
  logic                    ch_v   [MO+1];
  logic [CW-1:0]           ch_x   [MO+1];
  logic [CW-1:0]           ch_y   [MO+1];
  logic signed [ACC_W-1:0] ch_acc [MO+1];
  logic [AW-1:0]           ch_amp [MO+1];
  logic [15:0]             px16_w, py16_w;

  assign px16_w = 16'(in_item.pixel_x);
  assign py16_w = 16'(in_item.pixel_y);

  logic v0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else        v0_r <= start && !busy;
  end

  logic [CW-1:0] x0_r, y0_r;
  always_ff @(posedge clk) begin
    x0_r <= px16_w[CW-1:0] & mask_w[CW-1:0];
    y0_r <= py16_w[CW-1:0] & mask_w[CW-1:0];
  end

  assign ch_v[0]   = v0_r;
  assign ch_x[0]   = x0_r;
  assign ch_y[0]   = y0_r;
  assign ch_acc[0] = '0;
  assign ch_amp[0] = AW'(32768);

  for (genvar k = 0; k < MO; k++) begin : g_oct
    fvnh_octave #(.K(k), .CW(CW), .AW(AW), .ACC_W(ACC_W)) u_oct (
      .clk    (clk),
      .rst_n  (rst_n),
      .seed   (seed_r),
      .rough  (rough_r),
      .rl     (rl_w),
      .oc     (oc_w),
      .in_v   (ch_v[k]),
      .in_x   (ch_x[k]),
      .in_y   (ch_y[k]),
      .in_acc (ch_acc[k]),
      .in_amp (ch_amp[k]),
      .out_v  (ch_v[k+1]),
      .out_x  (ch_x[k+1]),
      .out_y  (ch_y[k+1]),
      .out_acc(ch_acc[k+1]),
      .out_amp(ch_amp[k+1])
    );
  end

  // output stage: round half away, offset to mid height, saturate
  logic signed [ACC_W-1:0] acc_w, q_w, hs_w;
  logic [15:0]             h_w;
  logic [31:0]             idx_w;
  always_comb begin
    acc_w = ch_acc[MO];
    if (acc_w >= 0) q_w = (acc_w + ACC_W'(16384)) >>> 15;
    else            q_w = -(((-acc_w) + ACC_W'(16384)) >>> 15);
    hs_w = q_w + ACC_W'(32768);
    if (hs_w < 0)                      h_w = 16'd0;
    else if (hs_w > ACC_W'(65535))     h_w = 16'hFFFF;
    else                               h_w = hs_w[15:0];
    idx_w = (32'(ch_y[MO]) << rl_w) + 32'(ch_x[MO]);
  end

  logic                 strobe_r;
  fvnh_pkg::out_item_t  item_r;
  always_ff @(posedge clk) begin
    if (!rst_n) strobe_r <= 1'b0;
    else        strobe_r <= ch_v[MO];
  end
  always_ff @(posedge clk) begin
    item_r.height_q16  <= h_w;
    item_r.pixel_index <= idx_w[23:0];
  end

  assign out_strobe = strobe_r;
  assign out_item   = item_r;

`ifndef SYNTHESIS
  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    ch_v[MO] |=> out_strobe) else $error("result from last octave not delivered");
  a_no_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    !ch_v[MO] |=> !out_strobe) else $error("result strobe without an item");
  a_zero_oct: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && oc_w == 5'd0) |-> out_item.height_q16 == 16'h8000)
    else $error("zero octaves must give mid height");
  a_in_stage: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> ch_v[0]) else $error("accepted item missing from input stage");
`endif

endmodule

// ===== tb/fractal_value_noise_height_test.sv =====
// Testbench: fractal value-noise height block against a bit-exact in-bench predictor.
module fractal_value_noise_height_test;

  localparam int MAX_OCT  = 8;
  localparam int MAX_RL   = 12;
  localparam int LATENCY  = 8 * MAX_OCT + 2;
  localparam int WD_LIMIT = 20000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  fvnh_pkg::in_item_t    in_item = '0;
  logic                  out_strobe;
  fvnh_pkg::out_item_t   out_item;
  logic                  cfg_we = 1'b0;
  logic [fvnh_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [fvnh_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  fractal_value_noise_height i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // local copy of the register file
  logic [31:0] seed_r;
  logic [15:0] rough_r;
  logic [3:0]  octs_r;
  logic [3:0]  rlog_r;

  fvnh_pkg::out_item_t height_queue[$];
  int        errors = 0;
  int        idle_cycles = 0;

  // ---------------------------------------------------------------------------
  // Predictor helpers
  // ---------------------------------------------------------------------------
  function automatic longint round_away(longint v, int s);
    longint half;
    half = longint'(1) << (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -(((-v) + half) >>> s);
  endfunction

  function automatic longint lattice_value(logic [31:0] a, logic [31:0] b, logic [31:0] k);
    logic [31:0] h;
    h = (a * 32'd374761393 + b * 32'd668265263 + seed_r) ^ (k * 32'd1013904223);
    h = (h ^ (h >> 13)) * 32'd1274126177;
    return longint'(h[15:0]) - 32768;
  endfunction

  function automatic longint fade_q15(logic [15:0] t16);
    logic [63:0] t, prod;
    t = 64'(t16);
    prod = t * t * (64'd196608 - 64'd2 * t);
    return longint'((prod + (64'd1 << 32)) >> 33);
  endfunction

  function automatic longint mix(longint a, longint b, longint w);
    return a + round_away((b - a) * w, 15);
  endfunction

  function automatic fvnh_pkg::out_item_t predict_height(fvnh_pkg::in_item_t it);
    fvnh_pkg::out_item_t r;
    int          rl, oc;
    logic [63:0] mask, x, y, px, py, amp;
    longint      acc, h, wx, wy, r0, r1, n;
    logic [31:0] cx, cy;
    logic [15:0] tx, ty;
    rl = rlog_r;
    oc = octs_r;
    if (rl < 1) rl = 1;
    if (rl > MAX_RL) rl = MAX_RL;
    if (oc > MAX_OCT) oc = MAX_OCT;
    mask = (64'd1 << rl) - 1;
    x = 64'(it.pixel_x) & mask;
    y = 64'(it.pixel_y) & mask;
    amp = 64'd32768;
    acc = 0;
    for (int k = 0; k < oc; k++) begin
      px = x << k;
      py = y << k;
      cx = 32'((px >> rl) & 64'hFF);
      cy = 32'((py >> rl) & 64'hFF);
      tx = 16'((px & mask) << (16 - rl));
      ty = 16'((py & mask) << (16 - rl));
      wx = fade_q15(tx);
      wy = fade_q15(ty);
      r0 = mix(lattice_value(cx, cy, k), lattice_value(cx + 1, cy, k), wx);
      r1 = mix(lattice_value(cx, cy + 1, k), lattice_value(cx + 1, cy + 1, k), wx);
      n = mix(r0, r1, wy);
      acc += n * longint'(amp);
      amp = (amp * 64'(rough_r) + 64'd16384) >> 15;
    end
    h = 32768 + round_away(acc, 15);
    if (h < 0) h = 0;
    if (h > 65535) h = 65535;
    r.height_q16 = h[15:0];
    r.pixel_index = 24'((y << rl) + x);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // write enable stays up between back-to-back writes; setup lowers it
  task automatic write_reg(fvnh_pkg::cfg_reg_t idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      fvnh_pkg::REG_NOISE_SEED:    seed_r = val;
      fvnh_pkg::REG_ROUGHNESS_Q15: rough_r = val[15:0];
      fvnh_pkg::REG_OCTAVE_COUNT:  octs_r = val[3:0];
      fvnh_pkg::REG_RES_LOG2:      rlog_r = val[3:0];
      default: ;
    endcase
  endtask

  // sender gap, its length set by n
  task automatic idle(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_empty();
    start <= 1'b0;
    while (height_queue.size() != 0) @(posedge clk);
  endtask

  task automatic drain_pipe();
    wait_empty();
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic setup(logic [31:0] sd, logic [15:0] rg, logic [3:0] oc, logic [3:0] rl);
    drain_pipe();
    write_reg(fvnh_pkg::REG_NOISE_SEED, sd);
    write_reg(fvnh_pkg::REG_ROUGHNESS_Q15, 32'(rg));
    write_reg(fvnh_pkg::REG_OCTAVE_COUNT, 32'(oc));
    write_reg(fvnh_pkg::REG_RES_LOG2, 32'(rl));
    cfg_we <= 1'b0;
  endtask

  // one item; the expectation is queued at the edge that accepts it
  // start stays high so items can follow back to back
  task automatic send_pixel(logic [11:0] px, logic [11:0] py);
    fvnh_pkg::in_item_t it;
    it.pixel_x = px;
    it.pixel_y = py;
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    height_queue = {height_queue, predict_height(it)};
  endtask

  // burst of random pixels, random gaps between bursts
  task automatic random_pixels(int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 40);
      if ($urandom_range(0, 3) == 0) burst = 1;
      for (int i = 0; i < burst && count > 0; i++, count--)
        send_pixel(12'($urandom), 12'($urandom));
      if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 12));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    fvnh_pkg::out_item_t want;
    if (rst_n && out_strobe) begin
      if (height_queue.size() == 0) begin
        $display("%0t: unexpected item %h", $time, out_item);
        errors++;
      end else begin
        want = height_queue.pop_front();
        if (out_item.height_q16 !== want.height_q16) begin
          $display("%0t: height_q16 expected %h got %h", $time, want.height_q16,
                   out_item.height_q16);
          errors++;
        end
        if (out_item.pixel_index !== want.pixel_index) begin
          $display("%0t: pixel_index expected %h got %h", $time, want.pixel_index,
                   out_item.pixel_index);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with no item moving either way
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // reset defaults, corners of the coordinate range
  task automatic test_defaults();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'd255, 12'd0);
    send_pixel(12'd0, 12'd255);
    send_pixel(12'd128, 12'd77);
  endtask

  // zero octaves gives mid height; clamped octave and resolution values
  task automatic test_edges();
    setup(32'hDEADBEEF, 16'd16384, 4'd0, 4'd8);
    send_pixel(12'd17, 12'd200);
    setup(32'hFFFFFFFF, 16'hFFFF, 4'd15, 4'd15);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'hABC, 12'h543);
    setup(32'd0, 16'd0, 4'd8, 4'd0);
    send_pixel(12'hFFF, 12'd0);
    send_pixel(12'd1, 12'd1);
    setup(32'h12345678, 16'd32768, 4'd8, 4'd1);
    send_pixel(12'd1, 12'd0);
    send_pixel(12'd0, 12'd1);
    // finest resolution, all octaves, corners of the map
    setup(32'h0BADF00D, 16'd40000, 4'd8, 4'd12);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'hFF0, 12'h00F);
    send_pixel(12'd0, 12'hFFF);
  endtask

  // random settings, bursts of random pixels, one full drain mid-phase
  task automatic test_random();
    logic [3:0] oc, rl;
    for (int p = 0; p < 12; p++) begin
      oc = 4'($urandom_range(0, 15));
      rl = 4'($urandom);
      if (p % 3 != 0) rl = 4'($urandom_range(1, 12));
      setup($urandom, 16'($urandom), oc, rl);
      random_pixels(70);
      wait_empty();
      random_pixels(70);
    end
  endtask

  // ---------------------------------------------------------------------------
  initial begin
    seed_r = 32'd0;
    rough_r = 16'd16384;
    octs_r = 4'd4;
    rlog_r = 4'd8;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_edges();
    test_random();
    drain_pipe();
    if (errors == 0 && height_queue.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
